// File: hw/rtl/vlc2_pkg.sv
// Package for the 2-D vector length clamp: widths, reset value and the
// beat records that travel along the square-root and divider cell chains.
// No dependencies.
package vlc2_pkg;

  localparam int COMP_W     = 16;
  localparam int MAX_LEN_W  = 15;
  localparam int SQ_W       = 32;
  localparam int MAX_SQ_W   = 30;
  localparam int NUM_W      = 30;
  localparam int ROOT_W     = 16;
  localparam int REM_SQ_W   = 17;
  localparam int Q_W        = 15;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = Q_W;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 15'd256;
  localparam logic [MAX_SQ_W-1:0]  MAX_SQ_RESET  = 30'd65536;

  typedef struct packed {
    logic [COMP_W-1:0]   x;
    logic [COMP_W-1:0]   y;
    logic                clamp;
    logic [NUM_W-1:0]    nx;
    logic [NUM_W-1:0]    ny;
    logic [SQ_W-1:0]     rad;
    logic [REM_SQ_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_item_t;

  typedef struct packed {
    logic [COMP_W-1:0] x;
    logic [COMP_W-1:0] y;
    logic              clamp;
    logic [ROOT_W-1:0] div;
    logic [Q_W-1:0]    nlo_x;
    logic [Q_W-1:0]    nlo_y;
    logic [ROOT_W-1:0] rem_x;
    logic [ROOT_W-1:0] rem_y;
    logic [Q_W-1:0]    q_x;
    logic [Q_W-1:0]    q_y;
  } dv_item_t;

endpackage

// File: hw/rtl/vlc2_if.sv
// Stream interfaces for the vector clamp: input vectors and clamped results.
// Each carries valid, ready and the beat payload. Depends on vlc2_pkg.
interface vlc2_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [vlc2_pkg::COMP_W-1:0] x_in;
  logic signed [vlc2_pkg::COMP_W-1:0] y_in;

  modport source (output valid, output x_in, output y_in, input ready);
  modport sink (input valid, input x_in, input y_in, output ready);
endinterface

interface vlc2_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vlc2_pkg::COMP_W-1:0] x_out;
  logic signed [vlc2_pkg::COMP_W-1:0] y_out;
  logic                               was_clamped;

  modport source (output valid, output x_out, output y_out, output was_clamped,
                  input ready);
  modport sink (input valid, input x_out, input y_out, input was_clamped,
                output ready);
endinterface

// File: hw/rtl/vector_length_clamp_2d_unit.sv
// Top level of the 2-D vector length clamp: front stages, 16 square-root
// cells, 15 divider cells and the output register. Depends on vlc2_pkg,
// vlc2_if, vlc2_sqrt_cell and vlc2_div_cell.
// One beat per cycle is accepted while the output is not stalled; the root and
// divide chains resolve one bit per cell.
// Synchronous active-low reset empties the pipeline and sets max_length to 256.
module vector_length_clamp_2d_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  vlc2_in_if.sink                            in_ch,
  vlc2_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [vlc2_pkg::MAX_LEN_W-1:0]     cfg_wdata
);
  import vlc2_pkg::*;

  logic [MAX_LEN_W-1:0] max_length_r;
  logic [MAX_SQ_W-1:0]  max_sq_r;

  logic                 v0_r, v1_r, v2_r;
  logic                 go0, go1, go2, go_out;
  logic [COMP_W-1:0]    x0_r, y0_r, ax0_r, ay0_r;
  logic [COMP_W-1:0]    x1_r, y1_r, ax1_r, ay1_r;
  logic [SQ_W-1:0]      sqx1_r, sqy1_r;
  logic [COMP_W-1:0]    ax_nxt, ay_nxt;
  logic [SQ_W:0]        len_sq;
  logic [COMP_W+MAX_LEN_W-1:0] prod_x, prod_y;
  sq_item_t             s2_r;

  logic                 sq_valid [SQRT_CELLS+1];
  sq_item_t             sq_item  [SQRT_CELLS+1];
  logic                 sq_go    [SQRT_CELLS+1];
  logic                 dv_valid [DIV_CELLS+1];
  dv_item_t             dv_item  [DIV_CELLS+1];
  logic                 dv_go    [DIV_CELLS+1];

  logic                 out_valid_r;
  logic [COMP_W-1:0]    x_out_r, y_out_r;
  logic                 clamped_r;
  logic [COMP_W-1:0]    qx_ext, qy_ext, x_res, y_res;
  dv_item_t             last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LEN_RESET;
      max_sq_r     <= MAX_SQ_RESET;
    end else begin
      if (cfg_we) begin
        max_length_r <= cfg_wdata;
      end
      max_sq_r <= MAX_SQ_W'(max_length_r * max_length_r);
    end
  end

  assign go_out      = !out_valid_r || out_ch.ready;
  assign go2         = !v2_r || sq_go[0];
  assign go1         = !v1_r || go2;
  assign go0         = !v0_r || go1;
  assign in_ch.ready = go0;

  assign ax_nxt = in_ch.x_in[COMP_W-1] ? COMP_W'(~in_ch.x_in + 1'b1) : in_ch.x_in;
  assign ay_nxt = in_ch.y_in[COMP_W-1] ? COMP_W'(~in_ch.y_in + 1'b1) : in_ch.y_in;
  assign len_sq = {1'b0, sqx1_r} + {1'b0, sqy1_r};
  assign prod_x = (COMP_W+MAX_LEN_W)'(ax1_r) * (COMP_W+MAX_LEN_W)'(max_length_r);
  assign prod_y = (COMP_W+MAX_LEN_W)'(ay1_r) * (COMP_W+MAX_LEN_W)'(max_length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (go0) v0_r <= in_ch.valid;
      if (go1) v1_r <= v0_r;
      if (go2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go0) begin
      x0_r  <= in_ch.x_in;
      y0_r  <= in_ch.y_in;
      ax0_r <= ax_nxt;
      ay0_r <= ay_nxt;
    end
    if (go1) begin
      x1_r   <= x0_r;
      y1_r   <= y0_r;
      ax1_r  <= ax0_r;
      ay1_r  <= ay0_r;
      sqx1_r <= SQ_W'(ax0_r) * SQ_W'(ax0_r);
      sqy1_r <= SQ_W'(ay0_r) * SQ_W'(ay0_r);
    end
    if (go2) begin
      s2_r.x     <= x1_r;
      s2_r.y     <= y1_r;
      s2_r.clamp <= len_sq > {3'b000, max_sq_r};
      s2_r.nx    <= prod_x[NUM_W-1:0];
      s2_r.ny    <= prod_y[NUM_W-1:0];
      s2_r.rad   <= len_sq[SQ_W-1:0];
      s2_r.rem   <= '0;
      s2_r.root  <= '0;
    end
  end

  assign sq_valid[0] = v2_r;
  assign sq_item[0]  = s2_r;
  assign sq_go[SQRT_CELLS] = dv_go[0];

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    vlc2_sqrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (sq_valid[i]),
      .up_item    (sq_item[i]),
      .down_go    (sq_go[i+1]),
      .up_go      (sq_go[i]),
      .down_valid (sq_valid[i+1]),
      .down_item  (sq_item[i+1])
    );
  end

  always_comb begin
    dv_valid[0]      = sq_valid[SQRT_CELLS];
    dv_item[0].x     = sq_item[SQRT_CELLS].x;
    dv_item[0].y     = sq_item[SQRT_CELLS].y;
    dv_item[0].clamp = sq_item[SQRT_CELLS].clamp;
    dv_item[0].div   = sq_item[SQRT_CELLS].root;
    dv_item[0].nlo_x = sq_item[SQRT_CELLS].nx[Q_W-1:0];
    dv_item[0].nlo_y = sq_item[SQRT_CELLS].ny[Q_W-1:0];
    dv_item[0].rem_x = {1'b0, sq_item[SQRT_CELLS].nx[NUM_W-1:Q_W]};
    dv_item[0].rem_y = {1'b0, sq_item[SQRT_CELLS].ny[NUM_W-1:Q_W]};
    dv_item[0].q_x   = '0;
    dv_item[0].q_y   = '0;
  end

  assign dv_go[DIV_CELLS] = go_out;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    vlc2_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (dv_valid[i]),
      .up_item    (dv_item[i]),
      .down_go    (dv_go[i+1]),
      .up_go      (dv_go[i]),
      .down_valid (dv_valid[i+1]),
      .down_item  (dv_item[i+1])
    );
  end

  always_comb begin
    last   = dv_item[DIV_CELLS];
    qx_ext = {1'b0, last.q_x};
    qy_ext = {1'b0, last.q_y};
    if (last.clamp) begin
      x_res = last.x[COMP_W-1] ? COMP_W'(~qx_ext + 1'b1) : qx_ext;
      y_res = last.y[COMP_W-1] ? COMP_W'(~qy_ext + 1'b1) : qy_ext;
    end else begin
      x_res = last.x;
      y_res = last.y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go_out) begin
      out_valid_r <= dv_valid[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (go_out) begin
      x_out_r   <= x_res;
      y_out_r   <= y_res;
      clamped_r <= last.clamp;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.x_out       = x_out_r;
  assign out_ch.y_out       = y_out_r;
  assign out_ch.was_clamped = clamped_r;

  // The pipeline only refuses a beat when every stage and the output are full.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready && v0_r))
    else $error("input stalled while the pipeline had room");

  // A clamped result never exceeds the maximum in either component.
  a_clamped_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && clamped_r) |->
      (((x_out_r[COMP_W-1] ? COMP_W'(~x_out_r + 1'b1) : x_out_r) <= {1'b0, max_length_r})
       && ((y_out_r[COMP_W-1] ? COMP_W'(~y_out_r + 1'b1) : y_out_r)
           <= {1'b0, max_length_r})))
    else $error("clamped component above max_length");

  // The squared maximum follows the maximum in the next cycle.
  a_max_sq_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (max_sq_r == MAX_SQ_W'($past(max_length_r) * $past(max_length_r))))
    else $error("squared maximum out of step with max_length");

endmodule

// File: hw/rtl/vlc2_sqrt_cell.sv
// One cell of the square-root chain: resolves one root bit per beat and
// hands the beat to its right neighbor. Depends on vlc2_pkg.
module vlc2_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  vlc2_pkg::sq_item_t  up_item,
  input  logic                down_go,
  output logic                up_go,
  output logic                down_valid,
  output vlc2_pkg::sq_item_t  down_item
);
  import vlc2_pkg::*;

  logic                valid_r;
  sq_item_t            item_r;
  sq_item_t            item_nxt;
  logic [REM_SQ_W+1:0] trial_rem;
  logic [REM_SQ_W+1:0] trial_sub;
  logic                take;

  assign up_go      = !valid_r || down_go;
  assign down_valid = valid_r;
  assign down_item  = item_r;

  always_comb begin
    trial_rem = {up_item.rem, up_item.rad[SQ_W-1 -: 2]};
    trial_sub = {1'b0, up_item.root, 2'b01};
    take      = trial_rem >= trial_sub;
    item_nxt      = up_item;
    item_nxt.rad  = {up_item.rad[SQ_W-3:0], 2'b00};
    item_nxt.root = {up_item.root[ROOT_W-2:0], take};
    item_nxt.rem  = take ? REM_SQ_W'(trial_rem - trial_sub) : REM_SQ_W'(trial_rem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_go) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_go) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: hw/rtl/vlc2_div_cell.sv
// One cell of the divider chain: resolves one quotient bit of both scaled
// components per beat and passes the beat on. Depends on vlc2_pkg.
module vlc2_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  vlc2_pkg::dv_item_t  up_item,
  input  logic                down_go,
  output logic                up_go,
  output logic                down_valid,
  output vlc2_pkg::dv_item_t  down_item
);
  import vlc2_pkg::*;

  logic             valid_r;
  dv_item_t         item_r;
  dv_item_t         item_nxt;
  logic [ROOT_W:0]  part_x;
  logic [ROOT_W:0]  part_y;
  logic [ROOT_W:0]  div_ext;
  logic             ge_x;
  logic             ge_y;

  assign up_go      = !valid_r || down_go;
  assign down_valid = valid_r;
  assign down_item  = item_r;

  always_comb begin
    div_ext = {1'b0, up_item.div};
    part_x  = {up_item.rem_x, up_item.nlo_x[Q_W-1]};
    part_y  = {up_item.rem_y, up_item.nlo_y[Q_W-1]};
    ge_x    = part_x >= div_ext;
    ge_y    = part_y >= div_ext;
    item_nxt       = up_item;
    item_nxt.nlo_x = {up_item.nlo_x[Q_W-2:0], 1'b0};
    item_nxt.nlo_y = {up_item.nlo_y[Q_W-2:0], 1'b0};
    item_nxt.rem_x = ge_x ? ROOT_W'(part_x - div_ext) : part_x[ROOT_W-1:0];
    item_nxt.rem_y = ge_y ? ROOT_W'(part_y - div_ext) : part_y[ROOT_W-1:0];
    item_nxt.q_x   = {up_item.q_x[Q_W-2:0], ge_x};
    item_nxt.q_y   = {up_item.q_y[Q_W-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_go) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_go) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for vector_length_clamp_2d_unit: random and corner vectors
// under several max_length settings, checked beat by beat against an in-bench predictor.
// Depends on vlc2_pkg, vlc2_if and the RTL of the clamp unit.
module testbench;
  import vlc2_pkg::*;

  localparam int N_PHASES   = 9;
  localparam int RAND_ITEMS = 134;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 40;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
  } vec_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic                     clamped;
  } clamp_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [MAX_LEN_W-1:0] cfg_wdata;

  vlc2_in_if  in_ch ();
  vlc2_out_if out_ch ();

  vector_length_clamp_2d_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  vec_t                 pending_vecs[$];
  clamp_res_t           expected_q[$];
  logic [MAX_LEN_W-1:0] max_len_model;
  vec_t                 next_vec;
  clamp_res_t           want;
  bit                   in_taken;
  bit                   quiet;
  bit                   hold_start;
  int unsigned          hold_left;
  int unsigned          send_gap;
  int unsigned          stall_left;
  int unsigned          n_sent;
  int unsigned          n_in;
  int unsigned          n_done;
  int unsigned          n_clamped;
  int unsigned          n_errors;

  function automatic int unsigned floor_sqrt(input longint unsigned v);
    int unsigned     root;
    longint unsigned trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) begin
        root = 32'(trial);
      end
    end
    return root;
  endfunction

  function automatic logic [COMP_W-1:0] shrink_comp(input int c, input int unsigned lim,
                                                    input int unsigned len);
    longint q;
    q = (c < 0) ? -longint'(c) : longint'(c);
    q = (q * lim) / len;
    if (c < 0) begin
      q = -q;
    end
    return q[COMP_W-1:0];
  endfunction

  function automatic clamp_res_t clamp_vector(input vec_t v, input logic [MAX_LEN_W-1:0] lim);
    int              sx;
    int              sy;
    longint unsigned len_sq;
    longint unsigned lim_sq;
    int unsigned     len;
    clamp_res_t      r;
    sx = $signed(v.x);
    sy = $signed(v.y);
    len_sq = longint'(sx) * sx + longint'(sy) * sy;
    lim_sq = longint'(lim) * lim;
    if (len_sq > lim_sq) begin
      len = floor_sqrt(len_sq);
      r.x = shrink_comp(sx, lim, len);
      r.y = shrink_comp(sy, lim, len);
      r.clamped = 1'b1;
    end else begin
      r.x = v.x;
      r.y = v.y;
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  // Mostly back-to-back, often a few idle cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 45);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch on %0s at result %0d: got %0d, expected %0d",
             what, n_done, got, exp_val);
    n_errors++;
  endtask

  task automatic push_vec(input int x, input int y);
    vec_t v;
    v.x = x[COMP_W-1:0];
    v.y = y[COMP_W-1:0];
    pending_vecs.push_back(v);
    n_sent++;
  endtask

  // Random vectors are spread over the whole plane, around the limit circle,
  // over corner values and right on the circle where the root equals the limit.
  task automatic push_random_vec(input logic [MAX_LEN_W-1:0] lim);
    int corner_vals[5];
    int lim_i;
    int span;
    int x;
    int y;
    int unsigned mode;
    corner_vals = '{-32768, -1, 0, 1, 32767};
    lim_i = lim;
    span = lim_i + lim_i / 2 + 1;
    if (span > 32767) begin
      span = 32767;
    end
    mode = $urandom_range(0, 9);
    if (mode <= 3) begin
      x = int'($urandom_range(0, 65535)) - 32768;
      y = int'($urandom_range(0, 65535)) - 32768;
    end else if (mode <= 7) begin
      x = int'($urandom_range(0, 2 * span)) - span;
      y = int'($urandom_range(0, 2 * span)) - span;
    end else if (mode == 8) begin
      x = corner_vals[$urandom_range(0, 4)];
      y = corner_vals[$urandom_range(0, 4)];
    end else begin
      x = int'($urandom_range(0, 2 * lim_i)) - lim_i;
      y = floor_sqrt(lim_i * lim_i - x * x) + $urandom_range(0, 1);
      if (y > 32767) begin
        y = 32767;
      end
      if ($urandom_range(0, 1) == 1) begin
        y = -y;
      end
    end
    push_vec(x, y);
  endtask

  task automatic write_max_length(input logic [MAX_LEN_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    max_len_model = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_all_done();
    while (n_done < n_sent) begin
      @(negedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("timeout with %0d of %0d results received", n_done, n_sent);
    $display("[vector_length_clamp_2d_unit] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (pending_vecs.size() != 0) begin
        next_vec = pending_vecs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.x_in <= next_vec.x;
        in_ch.y_in <= next_vec.y;
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_left != 0) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      next_vec.x = in_ch.x_in;
      next_vec.y = in_ch.y_in;
      expected_q.push_back(clamp_vector(next_vec, max_len_model));
      n_in++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_done++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_ch.x_out, 0);
      end else begin
        want = expected_q.pop_front();
        if (want.clamped) begin
          n_clamped++;
        end
        if (out_ch.x_out !== want.x) begin
          report_mismatch("x_out", out_ch.x_out, want.x);
        end
        if (out_ch.y_out !== want.y) begin
          report_mismatch("y_out", out_ch.y_out, want.y);
        end
        if (out_ch.was_clamped !== want.clamped) begin
          report_mismatch("was_clamped", out_ch.was_clamped, want.clamped);
        end
      end
    end
  end

  initial begin
    logic [MAX_LEN_W-1:0] lim;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.x_in = '0;
    in_ch.y_in = '0;
    out_ch.ready = 1'b0;
    hold_start = 1'b0;
    quiet = 1'b0;
    max_len_model = MAX_LEN_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 0) begin
        lim = MAX_LEN_RESET;
      end else begin
        case (p)
          1: lim = '0;
          2: lim = '1;
          3: lim = 15'd1;
          4: lim = MAX_LEN_RESET;
          7: lim = MAX_LEN_W'($urandom_range(2, 64));
          default: lim = MAX_LEN_W'($urandom_range(0, 32767));
        endcase
        write_max_length(lim);
      end
      quiet = (p == 3 || p == 6);

      // The receiver is held off while a full phase of vectors is queued up,
      // so the pipeline fills and the input side has to stall.
      if (p == 2) begin
        @(negedge clk);
        hold_start = 1'b1;
        @(negedge clk);
        hold_start = 1'b0;
      end

      case (p)
        0: begin
          push_vec(0, 0);
          push_vec(256, 0);
          push_vec(0, -256);
          push_vec(257, 0);
          push_vec(256, 1);
          push_vec(181, 181);
          push_vec(182, 181);
          push_vec(-32768, -32768);
          push_vec(32767, 32767);
          push_vec(-32768, 32767);
          push_vec(-32768, 0);
          push_vec(0, -32768);
          push_vec(1, -1);
          push_vec(-100, 300);
        end
        1: begin
          push_vec(0, 0);
          push_vec(1, 0);
          push_vec(0, -1);
          push_vec(-32768, 32767);
        end
        2: begin
          push_vec(32767, 0);
          push_vec(-32768, 0);
          push_vec(-32768, -32768);
          push_vec(23170, 23170);
        end
        default: ;
      endcase
      repeat (RAND_ITEMS) push_random_vec(lim);
      wait_all_done();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    if (expected_q.size() != 0) begin
      report_mismatch("missing beats", 0, expected_q.size());
    end
    $display("%0d vectors sent over %0d max_length settings, %0d of them clamped",
             n_in, N_PHASES, n_clamped);
    $display("%0d results checked, %0d mismatches", n_done, n_errors);
    if (n_errors == 0) begin
      $display("[vector_length_clamp_2d_unit] OK");
    end else begin
      $display("[vector_length_clamp_2d_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/vlc2_pkg.sv
hw/rtl/vlc2_if.sv
hw/rtl/vlc2_sqrt_cell.sv
hw/rtl/vlc2_div_cell.sv
hw/rtl/vector_length_clamp_2d_unit.sv
dv/testbench.sv
